[sv/sac_pkg.sv]
// Shared types and constants for the size-aware FIFO cache.
package sac_pkg;
	localparam int ENTRIES = 32;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int KEY_W = 64;
	localparam int SIZE_W = 32;
	localparam int OCC_W = 40;
	localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};
	localparam logic [OCC_W-1:0] CAP_RESET = 40'd1048576;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_REMOVE = 1'b1;
	localparam logic KIND_EVICT = 1'b0;
	localparam logic KIND_FINAL = 1'b1;
	localparam logic [1:0] STS_OK = 2'd0;
	localparam logic [1:0] STS_ZERO = 2'd1;
	localparam logic [1:0] STS_ABSENT = 2'd2;
	localparam logic [1:0] STS_MISMATCH = 2'd3;

	typedef struct packed {
		logic operation;
		logic [KEY_W-1:0] object_key;
		logic [SIZE_W-1:0] object_size;
	} req_t;

	typedef struct packed {
		logic result_kind;
		logic [KEY_W-1:0] victim_key;
		logic [SIZE_W-1:0] evicted_size;
		logic hit;
		logic [1:0] status;
		logic [OCC_W-1:0] occupied_bytes;
		logic last;
	} rsp_t;

	// Queue entry: request plus the class the front decided on.
	typedef struct packed {
		req_t req;
		logic zero_size;
	} job_t;

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		next_slot = (i == IDX_W'(ENTRIES - 1)) ? '0 : i + 1'b1;
	endfunction
endpackage

[sv/sac_front.sv]
// Front end: accepts requests, classifies them and queues them for the back end.
module sac_front (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input sac_pkg::req_t req,
	output logic job_valid,
	output sac_pkg::job_t job,
	input logic job_pop
);
	import sac_pkg::*;

	job_t q_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push;

	assign req_stall = (cnt_q == 2'd2);
	assign push = req_valid && !req_stall;
	assign job_valid = (cnt_q != 2'd0);
	assign job = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q].req <= req;
			q_q[wr_q].zero_size <= (req.object_size == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (job_pop)
				rd_q <= ~rd_q;
			unique case ({push, job_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

[sv/sac_back.sv]
// Back end: slot table, key lookup, insert, eviction sequencer and result register.
module sac_back (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input sac_pkg::job_t job,
	output logic job_pop,
	input logic cfg_we,
	input logic [sac_pkg::OCC_W-1:0] cfg_wdata,
	output logic rsp_valid,
	input logic rsp_stall,
	output sac_pkg::rsp_t rsp
);
	import sac_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOOK = 3'd1;
	localparam logic [2:0] S_ACT = 3'd2;
	localparam logic [2:0] S_FULL = 3'd3;
	localparam logic [2:0] S_INS = 3'd4;
	localparam logic [2:0] S_EVICT = 3'd5;
	localparam logic [2:0] S_SKIP = 3'd6;
	localparam logic [2:0] S_FIN = 3'd7;

	logic [KEY_W-1:0] key_q [ENTRIES];
	logic [SIZE_W-1:0] size_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0] head_q, tail_q, fidx_q, new_q;
	logic [CNT_W-1:0] used_q;
	logic [OCC_W-1:0] occ_q, cap_q;
	logic [2:0] state_q, ret_q;
	job_t cur_q;
	logic hit_q, ins_q;
	logic [1:0] sts_q;

	logic [ENTRIES-1:0] match;
	logic [IDX_W-1:0] fidx;
	logic [IDX_W-1:0] rd_idx;
	logic [SIZE_W-1:0] rd_size;
	logic [OCC_W-1:0] occ_sub;
	logic [OCC_W:0] occ_add;
	logic out_free;
	logic full;
	logic need_evict;
	logic issue;

	always_comb begin
		fidx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (key_q[i] == cur_q.req.object_key);
			if (match[i])
				fidx = IDX_W'(i);
		end
	end

	assign rd_idx = (state_q == S_ACT) ? fidx_q : head_q;
	assign rd_size = size_q[rd_idx];
	assign occ_sub = (occ_q >= OCC_W'(rd_size)) ? occ_q - OCC_W'(rd_size) : '0;
	assign occ_add = {1'b0, occ_q} + (OCC_W+1)'(cur_q.req.object_size);
	assign out_free = !rsp_valid || !rsp_stall;
	assign full = (used_q >= CNT_W'(ENTRIES));
	assign need_evict = (occ_q > cap_q) && (used_q != '0);
	assign job_pop = (state_q == S_IDLE) && job_valid;
	// a beat is loaded into the result register this cycle
	assign issue = out_free && ((state_q == S_FULL && full) ||
		(state_q == S_EVICT && need_evict && !(ins_q && head_q == new_q)) ||
		state_q == S_FIN);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && job_valid)
			cur_q <= job;
		if (state_q == S_INS) begin
			key_q[tail_q] <= cur_q.req.object_key;
			size_q[tail_q] <= cur_q.req.object_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			used_q <= '0;
			occ_q <= '0;
			cap_q <= CAP_RESET;
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			fidx_q <= '0;
			new_q <= '0;
			hit_q <= 1'b0;
			ins_q <= 1'b0;
			sts_q <= STS_OK;
			rsp_valid <= 1'b0;
			rsp <= '0;
		end else begin
			if (cfg_we)
				cap_q <= cfg_wdata;
			if (issue)
				rsp_valid <= 1'b1;
			else if (!rsp_stall)
				rsp_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (job_valid)
						state_q <= S_LOOK;
				end
				S_LOOK: begin
					hit_q <= |match;
					fidx_q <= fidx;
					ins_q <= 1'b0;
					sts_q <= STS_OK;
					state_q <= S_ACT;
				end
				S_ACT: begin
					priority if (cur_q.req.operation == OP_REMOVE) begin
						if (!hit_q) begin
							sts_q <= STS_ABSENT;
							state_q <= S_FIN;
						end else begin
							occ_q <= occ_sub;
							valid_q[fidx_q] <= 1'b0;
							ret_q <= S_FIN;
							state_q <= S_SKIP;
						end
					end else if (cur_q.zero_size) begin
						sts_q <= STS_ZERO;
						state_q <= S_FIN;
					end else if (hit_q) begin
						if (rd_size != cur_q.req.object_size)
							sts_q <= STS_MISMATCH;
						state_q <= S_EVICT;
					end else begin
						state_q <= S_FULL;
					end
				end
				S_FULL: begin
					if (!full) begin
						state_q <= S_INS;
					end else if (out_free) begin
						rsp <= '{KIND_EVICT, key_q[head_q], rd_size, hit_q, STS_OK,
							occ_sub, 1'b0};
						occ_q <= occ_sub;
						valid_q[head_q] <= 1'b0;
						head_q <= next_slot(head_q);
						used_q <= used_q - 1'b1;
						ret_q <= S_INS;
						state_q <= S_SKIP;
					end
				end
				S_INS: begin
					valid_q[tail_q] <= 1'b1;
					new_q <= tail_q;
					ins_q <= 1'b1;
					tail_q <= next_slot(tail_q);
					used_q <= used_q + 1'b1;
					occ_q <= occ_add[OCC_W] ? OCC_MAX : occ_add[OCC_W-1:0];
					state_q <= S_EVICT;
				end
				S_EVICT: begin
					if (!need_evict) begin
						state_q <= S_FIN;
					end else if (out_free) begin
						// the new object itself is dropped without a report
						if (!(ins_q && head_q == new_q)) begin
							rsp <= '{KIND_EVICT, key_q[head_q], rd_size, hit_q, STS_OK,
								occ_sub, 1'b0};
						end
						occ_q <= occ_sub;
						valid_q[head_q] <= 1'b0;
						head_q <= next_slot(head_q);
						used_q <= used_q - 1'b1;
						ret_q <= S_EVICT;
						state_q <= S_SKIP;
					end
				end
				S_SKIP: begin
					if (used_q != '0 && !valid_q[head_q]) begin
						head_q <= next_slot(head_q);
						used_q <= used_q - 1'b1;
					end else begin
						state_q <= ret_q;
					end
				end
				S_FIN: begin
					if (out_free) begin
						rsp <= '{KIND_FINAL, '0, '0, hit_q, sts_q, occ_q, 1'b1};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[sv/size_aware_fifo_cache.sv]
// Top level of the size-aware FIFO cache.
// Requests enter on req (req_valid/req_stall); a beat is taken when valid is
// high and stall is low. operation selects access (lookup, insert on miss)
// or remove of a named key. Each request yields zero or more eviction beats
// followed by one final beat with last set, all on rsp (rsp_valid/rsp_stall).
// cfg_we/cfg_wdata write the byte capacity; write only while idle.
// Path of a request: it waits in the two-entry queue, then the back end
// loads it, compares keys and acts. A zero-size request or a remove of an
// absent key goes straight to the final beat; a hit access first passes the
// capacity check, a remove that hits a hole skip, and a miss the slot table
// check, insert and capacity check. Each eviction, full-table or capacity,
// adds a skip step, which also passes each hole left by a remove at the head.
// The back end takes one request at a time, so it is busy until the final
// beat of each request is loaded; the front queue keeps taking beats
// meanwhile, and req_stall rises only when two beats are waiting.
// When rsp is stalled the result register holds and the back end waits.
// Reset clears all slots, the occupied count and the pointers and sets the
// capacity to 1 MiB.
module size_aware_fifo_cache (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input sac_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output sac_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [sac_pkg::OCC_W-1:0] cfg_wdata
);
	import sac_pkg::*;

	logic job_valid, job_pop;
	job_t job;

	sac_front u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.job_valid(job_valid), .job(job), .job_pop(job_pop)
	);

	sac_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job(job), .job_pop(job_pop),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);
endmodule

[sv/sac_checker.sv]
// Port-level checks for the size-aware FIFO cache, bound to the top level.
module sac_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input sac_pkg::rsp_t rsp
);
	import sac_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled rsp beat changed");

	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.last == (rsp.result_kind == KIND_FINAL)))
		else $error("last does not match final beat");

	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == KIND_EVICT |-> rsp.status == STS_OK)
		else $error("eviction beat with nonzero status");

	a_final_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == KIND_FINAL |->
			rsp.victim_key == '0 && rsp.evicted_size == '0)
		else $error("final beat carries eviction data");
endmodule

bind size_aware_fifo_cache sac_checker u_checker (
	.clk(clk), .arst_n(arst_n),
	.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);

[tb/tb_size_aware_fifo_cache.sv]
// Testbench for the size-aware FIFO cache: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps
module tb_size_aware_fifo_cache;
	import sac_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic cfg_we;
	logic [OCC_W-1:0] cfg_wdata;

	size_aware_fifo_cache uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// cache mirror
	logic [KEY_W-1:0] m_keys [ENTRIES];
	logic [SIZE_W-1:0] m_sizes [ENTRIES];
	logic m_valid [ENTRIES];
	int m_head, m_tail, m_used;
	logic [OCC_W-1:0] m_occ;
	logic [OCC_W-1:0] m_cap;

	rsp_t pending_rsp [$];
	int n_err = 0;
	logic hold_req;
	logic hold_done;
	logic [KEY_W-1:0] key_pool [8];

	function automatic int nxt(input int i);
		return (i == ENTRIES - 1) ? 0 : i + 1;
	endfunction

	function automatic void occ_sub(input logic [SIZE_W-1:0] s);
		m_occ = (m_occ >= OCC_W'(s)) ? m_occ - OCC_W'(s) : '0;
	endfunction

	function automatic void skip_holes();
		while (m_used > 0 && !m_valid[m_head]) begin
			m_head = nxt(m_head);
			m_used--;
		end
	endfunction

	function automatic void push_rsp(input logic kind, input logic [KEY_W-1:0] k,
			input logic [SIZE_W-1:0] s, input logic h, input logic [1:0] st, input logic l);
		rsp_t r;
		r.result_kind = kind;
		r.victim_key = k;
		r.evicted_size = s;
		r.hit = h;
		r.status = st;
		r.occupied_bytes = m_occ;
		r.last = l;
		pending_rsp.push_back(r);
	endfunction

	function automatic void evict_head(input logic h, input logic report);
		logic [KEY_W-1:0] k;
		logic [SIZE_W-1:0] s;
		k = m_keys[m_head];
		s = m_sizes[m_head];
		m_valid[m_head] = 1'b0;
		occ_sub(s);
		m_head = nxt(m_head);
		m_used--;
		skip_holes();
		if (report)
			push_rsp(KIND_EVICT, k, s, h, STS_OK, 1'b0);
	endfunction

	function automatic void predict_cache(input req_t r);
		int found;
		int new_slot;
		logic h;
		logic [1:0] st;
		logic ins;
		logic [OCC_W:0] sum;
		found = -1;
		st = STS_OK;
		ins = 1'b0;
		new_slot = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (found < 0 && m_valid[i] && m_keys[i] == r.object_key)
				found = i;
		h = (found >= 0);
		if (r.operation == OP_REMOVE) begin
			if (found < 0) begin
				st = STS_ABSENT;
			end else begin
				occ_sub(m_sizes[found]);
				m_valid[found] = 1'b0;
				skip_holes();
			end
		end else if (r.object_size == '0) begin
			st = STS_ZERO;
		end else begin
			if (found >= 0) begin
				if (m_sizes[found] != r.object_size)
					st = STS_MISMATCH;
			end else begin
				while (m_used >= ENTRIES)
					evict_head(h, 1'b1);
				new_slot = m_tail;
				m_keys[new_slot] = r.object_key;
				m_sizes[new_slot] = r.object_size;
				m_valid[new_slot] = 1'b1;
				m_tail = nxt(m_tail);
				m_used++;
				sum = {1'b0, m_occ} + (OCC_W + 1)'(r.object_size);
				m_occ = sum[OCC_W] ? OCC_MAX : sum[OCC_W-1:0];
				ins = 1'b1;
			end
			while (m_occ > m_cap && m_used > 0)
				evict_head(h, !(ins && m_head == new_slot));
		end
		push_rsp(KIND_FINAL, '0, '0, h, st, 1'b1);
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb_size_aware_fifo_cache: done, errors");
		$finish;
	end

	// response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected beat %p", rsp);
				n_err++;
			end else begin : chk
				rsp_t e;
				e = pending_rsp.pop_front();
				if (rsp.result_kind !== e.result_kind) begin
					$error("result_kind exp %0h got %0h", e.result_kind, rsp.result_kind);
					n_err++;
				end
				if (rsp.victim_key !== e.victim_key) begin
					$error("victim_key exp %0h got %0h", e.victim_key, rsp.victim_key);
					n_err++;
				end
				if (rsp.evicted_size !== e.evicted_size) begin
					$error("evicted_size exp %0h got %0h", e.evicted_size, rsp.evicted_size);
					n_err++;
				end
				if (rsp.hit !== e.hit) begin
					$error("hit exp %0h got %0h", e.hit, rsp.hit);
					n_err++;
				end
				if (rsp.status !== e.status) begin
					$error("status exp %0h got %0h", e.status, rsp.status);
					n_err++;
				end
				if (rsp.occupied_bytes !== e.occupied_bytes) begin
					$error("occupied_bytes exp %0h got %0h", e.occupied_bytes,
						rsp.occupied_bytes);
					n_err++;
				end
				if (rsp.last !== e.last) begin
					$error("last exp %0h got %0h", e.last, rsp.last);
					n_err++;
				end
			end
		end
	end

	// receiver stall pattern; hold_req asks once for a long back-pressure stretch
	initial begin
		int mode;
		rsp_stall = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				rsp_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_done = 1'b1;
				rsp_stall <= 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				if (mode == 0)
					rsp_stall <= 1'b0;
				else
					rsp_stall <= ($urandom_range(0, 99) < mode * 20);
			end
		end
	end

	task automatic send_beat(input req_t r);
		@(negedge clk);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_cache(r);
		// keep valid high if the next beat follows at once
		if ($urandom_range(0, 3) == 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	endtask

	task automatic drain_all();
		int guard;
		guard = 0;
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		if (guard >= 200000) begin
			$display("tb_size_aware_fifo_cache: done, errors");
			$finish;
		end
		repeat (60) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [OCC_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		m_cap = v;
	endtask

	function automatic req_t mk(input logic op, input logic [KEY_W-1:0] k,
			input logic [SIZE_W-1:0] s);
		req_t r;
		r.operation = op;
		r.object_key = k;
		r.object_size = s;
		return r;
	endfunction

	typedef struct {
		req_t r;
		logic chk_final;
		logic [1:0] st;
		logic h;
	} dir_row_t;

	function automatic req_t rand_req(input int mode);
		req_t r;
		int pick;
		r.object_key = key_pool[$urandom_range(0, 7)];
		if (mode == 1)
			r.object_key = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		r.operation = (pick < 15) ? OP_REMOVE : OP_ACCESS;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			r.object_size = '0;
		else if (pick < 10)
			r.object_size = {$urandom};
		else
			r.object_size = $urandom_range(1, 4096);
		return r;
	endfunction

	initial begin
		dir_row_t dir_rows [$];
		dir_row_t row;
		rsp_t exp_final;
		int n_dir_err;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_req = 1'b0;
		n_dir_err = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			m_valid[i] = 1'b0;
			m_keys[i] = '0;
			m_sizes[i] = '0;
		end
		m_head = 0;
		m_tail = 0;
		m_used = 0;
		m_occ = '0;
		m_cap = CAP_RESET;
		for (int i = 0; i < 8; i++)
			key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: st/h checked on the final beat where marked
		dir_rows = '{
			'{mk(OP_REMOVE, 64'h0, 32'h0), 1'b1, STS_ABSENT, 1'b0},
			'{mk(OP_ACCESS, 64'h0, 32'h0), 1'b1, STS_ZERO, 1'b0},
			'{mk(OP_ACCESS, 64'h0, 32'h1), 1'b1, STS_OK, 1'b0},
			'{mk(OP_ACCESS, 64'h0, 32'h1), 1'b1, STS_OK, 1'b1},
			'{mk(OP_ACCESS, 64'h0, 32'h2), 1'b1, STS_MISMATCH, 1'b1},
			'{mk(OP_ACCESS, '1, 32'hFFFF_FFFF), 1'b0, STS_OK, 1'b0},
			'{mk(OP_ACCESS, 64'h5, 32'h100), 1'b0, STS_OK, 1'b0},
			'{mk(OP_ACCESS, 64'h6, 32'hF_0000), 1'b0, STS_OK, 1'b0},
			'{mk(OP_REMOVE, 64'h5, 32'h0), 1'b1, STS_OK, 1'b1},
			'{mk(OP_REMOVE, 64'h5, 32'hFFFF_FFFF), 1'b1, STS_ABSENT, 1'b0}
		};
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_beat(row.r);
			if (row.chk_final) begin
				exp_final = pending_rsp[$];
				if (exp_final.status !== row.st) begin
					$error("directed row %0d: status exp %0h got %0h", i, row.st,
						exp_final.status);
					n_dir_err++;
				end
				if (exp_final.hit !== row.h) begin
					$error("directed row %0d: hit exp %0h got %0h", i, row.h,
						exp_final.hit);
					n_dir_err++;
				end
			end
		end
		// fill past the slot table to force full-table evictions
		for (int i = 0; i < ENTRIES + 4; i++)
			send_beat(mk(OP_ACCESS, 64'h1000 + i, 32'h10));
		drain_all();

		// lower capacity, then an access evicts down to it
		write_capacity(40'd100);
		send_beat(mk(OP_ACCESS, 64'h1010, 32'h10));
		send_beat(mk(OP_ACCESS, 64'h2000, 32'd200));
		drain_all();
		write_capacity('0);
		send_beat(mk(OP_ACCESS, 64'h3000, 32'h1));
		drain_all();
		write_capacity(OCC_MAX);
		for (int i = 0; i < 40; i++)
			send_beat(mk(OP_ACCESS, 64'h4000 + i, 32'hFFFF_FFFF));
		drain_all();

		// random phases over several capacities
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: write_capacity(40'd1);
			1: write_capacity(40'd20000);
			2: write_capacity(CAP_RESET);
			default: write_capacity({8'($urandom_range(1, 255)), $urandom});
			endcase
			if (ph == 1)
				hold_req = 1'b1;
			for (int i = 0; i < 60; i++) begin
				send_beat(rand_req(($urandom_range(0, 9) == 0) ? 1 : 0));
				if ($urandom_range(0, 15) == 0) begin
					@(negedge clk);
					req_valid <= 1'b0;
					repeat ($urandom_range(5, 40)) @(negedge clk);
				end
			end
			drain_all();
		end

		if (n_err == 0 && n_dir_err == 0)
			$display("tb_size_aware_fifo_cache: done, clean");
		else
			$display("tb_size_aware_fifo_cache: done, errors");
		$finish;
	end
endmodule

[filelist.f]
sv/sac_pkg.sv
sv/sac_front.sv
sv/sac_back.sv
sv/size_aware_fifo_cache.sv
sv/sac_checker.sv
tb/tb_size_aware_fifo_cache.sv
